// ===== rtl/glpw_pkg.sv =====
// ----------------------------------------------------------------------------
// glpw_pkg: shared types and constants for the grid line passability walk
// Grid size, field widths, FSM state encoding and divider result bundle.
// ----------------------------------------------------------------------------
package glpw_pkg;

    // grid is 2^COORD_BITS x 2^COORD_BITS cells (valid range 4..12)
    localparam int COORD_BITS = 8;
    // width of every coordinate field on the ports
    localparam int FIELD_W    = 8;
    // one map row per RAM word
    localparam int ROW_W      = 2 ** COORD_BITS;
    localparam int ROWS       = 2 ** COORD_BITS;
    localparam int DIV_CNT_W  = $clog2(COORD_BITS + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic [FIELD_W-1:0]    t_field;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_DIV,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   done;
        t_coord quo;
        t_coord rem;
    } t_div_res;

    // port field -> grid coordinate (wraps to the grid size)
    function automatic t_coord to_coord(t_field f);
        logic [FIELD_W+COORD_BITS-1:0] tmp;
        tmp = {{COORD_BITS{1'b0}}, f};
        return tmp[COORD_BITS-1:0];
    endfunction

    // grid coordinate -> port field (zero extend or truncate)
    function automatic t_field to_field(t_coord c);
        logic [FIELD_W+COORD_BITS-1:0] tmp;
        tmp = {{FIELD_W{1'b0}}, c};
        return tmp[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/glpw_if.sv =====
// ----------------------------------------------------------------------------
// glpw_if: stream interfaces of the grid line passability walk
// Command word channel and result word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface glpw_in_if;
    import glpw_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    t_field cell_x;
    t_field cell_y;
    logic   passable;
    t_field start_x;
    t_field start_y;
    t_field end_x;
    t_field end_y;

    modport source (
        output valid, cmd, cell_x, cell_y, passable, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_x, cell_y, passable, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface glpw_out_if;
    import glpw_pkg::*;

    logic   valid;
    logic   ready;
    logic   clear;
    t_field reach_x;
    t_field reach_y;

    modport source (output valid, clear, reach_x, reach_y, input ready);
    modport sink   (input valid, clear, reach_x, reach_y, output ready);
endinterface

// ===== rtl/glpw_ram.sv =====
// ----------------------------------------------------------------------------
// glpw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module glpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/glpw_div.sv =====
// ----------------------------------------------------------------------------
// glpw_div: restoring unsigned divider
// One quotient bit per cycle; done pulses for one cycle with quo and rem.
// ----------------------------------------------------------------------------
module glpw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  glpw_pkg::t_coord  i_dividend,
    input  glpw_pkg::t_coord  i_divisor,
    output glpw_pkg::t_div_res o_res
);
    import glpw_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    t_coord               r_aq, n_aq;
    t_coord               r_rem, n_rem;
    t_coord               r_d, n_d;
    logic [COORD_BITS:0]  shifted;
    logic [COORD_BITS:0]  diff;

    always_comb begin
        shifted = {r_rem, r_aq[COORD_BITS-1]};
        diff    = shifted - {1'b0, r_d};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_aq    = r_aq;
        n_rem   = r_rem;
        n_d     = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(COORD_BITS);
            n_aq   = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_d}) begin
                n_rem = diff[COORD_BITS-1:0];
                n_aq  = {r_aq[COORD_BITS-2:0], 1'b1};
            end else begin
                n_rem = shifted[COORD_BITS-1:0];
                n_aq  = {r_aq[COORD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_aq  <= n_aq;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_aq;
    assign o_res.rem  = r_rem;
endmodule

// ===== rtl/grid_line_passability_walk.sv =====
// ----------------------------------------------------------------------------
// grid_line_passability_walk: line-of-sight walk over a passability bitmap
// Keeps a blocked/passable bit per grid cell and walks lines through it.
// ----------------------------------------------------------------------------
// The block holds a 2^COORD_BITS x 2^COORD_BITS passability map in one RAM,
// one grid row per RAM word. Right after reset a clearing pass writes every
// row to "blocked"; no command word is taken during the clearing pass. A
// write word (cmd=0) goes through accept, row read and write-back of the
// modified row. It produces no result. A check word (cmd=1) produces exactly
// one result word. It passes through the slope divider (skipped for a
// vertical line), then costs one RAM read per visited cell, and the next
// read is issued in the same cycle the previous one is tested. One command
// is processed at a time; the result sits in an output register, so a new
// command word is taken while the previous result waits to be read.
// ----------------------------------------------------------------------------
module grid_line_passability_walk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    glpw_in_if.sink    i_in,
    glpw_out_if.source o_out
);
    import glpw_pkg::*;

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    // clearing pass row counter
    t_coord r_clr_cnt, n_clr_cnt;

    // latched write word
    t_coord r_wx, n_wx;
    t_coord r_wy, n_wy;
    logic   r_wv, n_wv;

    // walk: front = last cell issued to the RAM, reach = last cell confirmed
    t_coord r_fx, n_fx;
    t_coord r_fy, n_fy;
    t_coord r_fny, n_fny;      // row the current column run heads for
    t_coord r_rx, n_rx;
    t_coord r_ry, n_ry;
    t_coord r_cols, n_cols;    // column cells still to issue
    t_coord r_steps, n_steps;  // |x2 - x1|
    t_coord r_acc, n_acc;      // remainder of rise*k / steps
    t_coord r_q0, n_q0;        // floor(rise / steps), modulo grid size
    t_coord r_r0, n_r0;        // rise mod steps (non-negative)
    logic   r_sx, n_sx;        // 1: walk toward larger x
    logic   r_neg, n_neg;      // rise is negative
    logic   r_pend, n_pend;    // a RAM read for the front cell is in flight
    logic   r_ok, n_ok;

    // output register
    logic   r_ovld, n_ovld;
    logic   r_oclear, n_oclear;
    t_field r_ox, n_ox;
    t_field r_oy, n_oy;

    // --------------------------------------------------------- input decode
    logic   in_ready;
    logic   in_acc;
    t_coord in_x1, in_y1, in_x2, in_y2;
    t_coord in_steps, in_rise_abs;
    logic   in_vert;

    assign in_ready = (r_state == S_IDLE);
    assign in_acc   = i_in.valid && in_ready;

    assign in_x1       = to_coord(i_in.start_x);
    assign in_y1       = to_coord(i_in.start_y);
    assign in_x2       = to_coord(i_in.end_x);
    assign in_y2       = to_coord(i_in.end_y);
    assign in_steps    = (in_x2 > in_x1) ? in_x2 - in_x1 : in_x1 - in_x2;
    assign in_rise_abs = (in_y2 >= in_y1) ? in_y2 - in_y1 : in_y1 - in_y2;
    assign in_vert     = (in_x1 == in_x2);

    // ------------------------------------------------------------- RAM/div
    logic     ram_we;
    t_coord   ram_waddr;
    t_row     ram_wdata;
    logic     ram_re;
    t_coord   ram_raddr;
    t_row     ram_rdata;
    logic     div_start;
    t_div_res div_res;

    glpw_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    glpw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_rise_abs),
        .i_divisor  (in_steps),
        .o_res      (div_res)
    );

    // ------------------------------------------------------- walk helpers
    logic                w_bit;      // tested cell is passable
    logic                w_blk;      // pending cell came back blocked
    logic                w_row;      // still rows to run in this column
    logic                w_more;
    logic                w_issue;
    t_coord              w_row_nxt;
    t_coord              w_col_nxt;
    t_coord              w_addr;
    logic [COORD_BITS:0] acc_sum;
    logic [COORD_BITS:0] acc_sub;
    logic                acc_wrap;
    t_coord              acc_nxt;
    t_coord              fny_nxt;
    t_row                wr_row;
    logic                out_free;

    always_comb begin
        w_bit     = ram_rdata[r_fx];
        w_blk     = r_pend && !w_bit;
        w_row     = (r_fy != r_fny);
        w_more    = w_row || (r_cols != '0);
        w_issue   = (r_state == S_WALK) && !w_blk && w_more;
        w_row_nxt = (r_fny > r_fy) ? r_fy + 1'b1 : r_fy - 1'b1;
        w_col_nxt = r_sx ? r_fx + 1'b1 : r_fx - 1'b1;
        // a run walks the old column; a column step reads the target row
        w_addr    = w_row ? w_row_nxt : r_fny;

        // incremental floor(rise*k/steps): add the per-column quotient/rem
        acc_sum  = {1'b0, r_acc} + {1'b0, r_r0};
        acc_sub  = acc_sum - {1'b0, r_steps};
        acc_wrap = (acc_sum >= {1'b0, r_steps});
        acc_nxt  = acc_wrap ? acc_sub[COORD_BITS-1:0] : acc_sum[COORD_BITS-1:0];
        fny_nxt  = r_fny + r_q0 + {{(COORD_BITS-1){1'b0}}, acc_wrap};

        wr_row       = ram_rdata;
        wr_row[r_wx] = r_wv;

        out_free = !r_ovld || o_out.ready;
    end

    // ----------------------------------------------------- FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_cnt == t_coord'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.cmd == CMD_WRITE) begin
                        n_state = S_WR_RD;
                    end else if (in_vert) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_WR_RD: n_state = S_WR_WB;
            S_WR_WB: n_state = S_IDLE;
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_blk || !w_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // --------------------------------------------------------- FSM outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wy;
        ram_wdata = wr_row;
        ram_re    = 1'b0;
        ram_raddr = w_addr;
        div_start = 1'b0;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = '0;
            end
            S_IDLE: begin
                div_start = in_acc && (i_in.cmd == CMD_CHECK) && !in_vert;
            end
            S_WR_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_wy;
            end
            S_WR_WB: begin
                // read and write-back never overlap another access: the FSM
                // serializes commands, so no forwarding is needed
                ram_we = 1'b1;
            end
            S_WALK: begin
                ram_re = w_issue;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        n_clr_cnt = r_clr_cnt;
        n_wx      = r_wx;
        n_wy      = r_wy;
        n_wv      = r_wv;
        n_fx      = r_fx;
        n_fy      = r_fy;
        n_fny     = r_fny;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_cols    = r_cols;
        n_steps   = r_steps;
        n_acc     = r_acc;
        n_q0      = r_q0;
        n_r0      = r_r0;
        n_sx      = r_sx;
        n_neg     = r_neg;
        n_pend    = r_pend;
        n_ok      = r_ok;
        n_ovld    = r_ovld;
        n_oclear  = r_oclear;
        n_ox      = r_ox;
        n_oy      = r_oy;

        case (r_state)
            S_CLR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_wx    = to_coord(i_in.cell_x);
                    n_wy    = to_coord(i_in.cell_y);
                    n_wv    = i_in.passable;
                    // start cell is reach, never tested
                    n_fx    = in_x1;
                    n_fy    = in_y1;
                    n_rx    = in_x1;
                    n_ry    = in_y1;
                    n_sx    = (in_x2 > in_x1);
                    n_neg   = (in_y2 < in_y1);
                    n_steps = in_steps;
                    n_pend  = 1'b0;
                    n_ok    = 1'b1;
                    if (in_vert) begin
                        n_fny  = in_y2;
                        n_cols = '0;
                    end else begin
                        n_cols = in_steps;
                    end
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    // floor division of a signed rise by positive steps
                    if (!r_neg) begin
                        n_q0 = div_res.quo;
                        n_r0 = div_res.rem;
                    end else if (div_res.rem != '0) begin
                        n_q0 = ~div_res.quo;
                        n_r0 = r_steps - div_res.rem;
                    end else begin
                        n_q0 = ~div_res.quo + 1'b1;
                        n_r0 = '0;
                    end
                    n_acc = n_r0;
                    n_fny = r_fy + n_q0;
                end
            end
            S_WALK: begin
                if (w_blk) begin
                    n_ok   = 1'b0;
                    n_pend = 1'b0;
                end else begin
                    if (r_pend) begin
                        n_rx = r_fx;
                        n_ry = r_fy;
                    end
                    n_pend = w_more;
                    if (w_more) begin
                        if (w_row) begin
                            n_fy = w_row_nxt;
                        end else begin
                            n_fx   = w_col_nxt;
                            n_fy   = r_fny;
                            n_cols = r_cols - 1'b1;
                            // target of the following column, not past the end
                            if (r_cols != t_coord'(1)) begin
                                n_acc = acc_nxt;
                                n_fny = fny_nxt;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        if (r_ovld && o_out.ready) begin
            n_ovld = 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            n_ovld   = 1'b1;
            n_oclear = r_ok;
            n_ox     = to_field(r_rx);
            n_oy     = to_field(r_ry);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_pend    <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_pend    <= n_pend;
            r_ovld    <= n_ovld;
        end
        r_wx     <= n_wx;
        r_wy     <= n_wy;
        r_wv     <= n_wv;
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_fny    <= n_fny;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_cols   <= n_cols;
        r_steps  <= n_steps;
        r_acc    <= n_acc;
        r_q0     <= n_q0;
        r_r0     <= n_r0;
        r_sx     <= n_sx;
        r_neg    <= n_neg;
        r_ok     <= n_ok;
        r_oclear <= n_oclear;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
    end

    // ---------------------------------------------------------------- ports
    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_ovld;
    assign o_out.clear   = r_oclear;
    assign o_out.reach_x = r_ox;
    assign o_out.reach_y = r_oy;

endmodule

// ===== rtl/glpw_chk.sv =====
// ----------------------------------------------------------------------------
// glpw_chk: port-level checks for the grid line passability walk
// Result handshake rules, command serialization and reset behavior.
// ----------------------------------------------------------------------------
module glpw_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_clear,
    input glpw_pkg::t_field i_out_x,
    input glpw_pkg::t_field i_out_y
);
    import glpw_pkg::*;

    // a result word waits until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable({i_out_clear, i_out_x, i_out_y}))
        else $error("result word changed while stalled");

    // one command at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command taken while previous one in progress");

    // no result can appear in the cycle after a command is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result word appeared too early");

    // reset empties the output and starts the map clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("block not quiet after reset");

endmodule

bind grid_line_passability_walk glpw_chk u_glpw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_clear (o_out.clear),
    .i_out_x     (o_out.reach_x),
    .i_out_y     (o_out.reach_y)
);

// ===== test/tb_grid_line_passability_walk.sv =====
// ----------------------------------------------------------------------------
// tb_grid_line_passability_walk: self-checking bench for the line-of-sight walk
// Drives map writes and line checks over the command channel, predicts each
// walk from a private copy of the passability map, and checks every result
// word in order. Handshake idling moves between sender and receiver.
// ----------------------------------------------------------------------------
module tb_grid_line_passability_walk;
    timeunit 1ns;
    timeprecision 1ps;

    import glpw_pkg::*;

    localparam int GRID_MASK = (1 << COORD_BITS) - 1;
    localparam int MAP_CELLS = 1 << (2 * COORD_BITS);
    localparam int FIELD_MAX = (1 << FIELD_W) - 1;
    // full diagonal walk plus divider and overhead, with margin
    localparam int DRAIN_CYCLES = 2 * ROWS + COORD_BITS + 64;

    typedef struct packed {
        logic   cmd;
        t_field cell_x;
        t_field cell_y;
        logic   passable;
        t_field start_x;
        t_field start_y;
        t_field end_x;
        t_field end_y;
    } t_cmd_word;

    typedef struct packed {
        logic   clear;
        t_field reach_x;
        t_field reach_y;
    } t_walk_result;

    // Map copy, walk predictor and queue of expected walk results.
    class walk_scoreboard;
        bit           open_map [MAP_CELLS];
        t_walk_result pending_walks [$];
        int           path_x [$];
        int           path_y [$];
        bit           tracing;
        bit           walk_ok;
        int           walk_x;
        int           walk_y;
        int           mismatches;
        int           n_writes;
        int           n_checks;
        int           n_clear;

        function int cell_idx(int x, int y);
            return ((y & GRID_MASK) << COORD_BITS) | (x & GRID_MASK);
        endfunction

        // in trace mode every tested cell is recorded and treated as open
        function bit cell_open(int x, int y);
            if (tracing) begin
                path_x = {path_x, x & GRID_MASK};
                path_y = {path_y, y & GRID_MASK};
                return 1'b1;
            end
            return open_map[cell_idx(x, y)];
        endfunction

        // rows after row, up to and including target, in column col
        function void walk_column(int col, int row, int target);
            int j;
            j = row;
            while (walk_ok && j != target) begin
                j = (target > j) ? j + 1 : j - 1;
                if (!cell_open(col, j)) begin
                    walk_ok = 1'b0;
                    return;
                end
                walk_x = col;
                walk_y = j;
            end
        endfunction

        function t_walk_result predict_walk(int x1, int y1, int x2, int y2);
            longint       den;
            longint       rise;
            longint       num;
            longint       q;
            int           steps;
            int           cx;
            int           ny;
            int           lx;
            int           ly;
            int           i;
            t_walk_result r;
            walk_ok = 1'b1;
            walk_x  = x1;
            walk_y  = y1;
            if (x1 == x2) begin
                walk_column(x1, y1, y2);
            end else begin
                den   = x2 - x1;
                rise  = y2 - y1;
                steps = (x2 > x1) ? x2 - x1 : x1 - x2;
                lx    = x1;
                ly    = y1;
                for (i = 0; i < steps && walk_ok; i++) begin
                    cx  = (x2 > x1) ? x1 + 1 + i : x1 - 1 - i;
                    num = longint'(y2) * den + rise * longint'(cx - x2);
                    // floor division, exact
                    q = num / den;
                    if ((num % den) != 0 && ((num < 0) != (den < 0)))
                        q = q - 1;
                    ny = int'(q & GRID_MASK);
                    walk_column(lx, ly, ny);
                    if (!walk_ok)
                        break;
                    if (!cell_open(cx, ny)) begin
                        walk_ok = 1'b0;
                        break;
                    end
                    walk_x = cx;
                    walk_y = ny;
                    lx     = cx;
                    ly     = ny;
                end
            end
            r.clear   = walk_ok;
            r.reach_x = t_field'(walk_x & 'hFF);
            r.reach_y = t_field'(walk_y & 'hFF);
            return r;
        endfunction

        // cells a walk would test if the whole line were open
        function void trace_line(int x1, int y1, int x2, int y2);
            t_walk_result unused;
            path_x.delete();
            path_y.delete();
            tracing = 1'b1;
            unused  = predict_walk(x1, y1, x2, y2);
            tracing = 1'b0;
        endfunction

        function void note_word(t_cmd_word w);
            t_walk_result r;
            if (w.cmd == CMD_WRITE) begin
                open_map[cell_idx(w.cell_x, w.cell_y)] = w.passable;
                n_writes++;
            end else begin
                r = predict_walk(w.start_x & GRID_MASK, w.start_y & GRID_MASK,
                                 w.end_x & GRID_MASK, w.end_y & GRID_MASK);
                pending_walks = {pending_walks, r};
                n_checks++;
                if (r.clear)
                    n_clear++;
            end
        endfunction

        function void check_result(logic clear, t_field reach_x, t_field reach_y);
            t_walk_result want;
            if (pending_walks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: clear=%0b reach=(%0d,%0d)",
                             $realtime, clear, reach_x, reach_y);
                return;
            end
            want = pending_walks.pop_front();
            if (clear !== want.clear || reach_x !== want.reach_x
                    || reach_y !== want.reach_y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] walk mismatch: exp clear=%0b reach=(%0d,%0d)",
                             $realtime, want.clear, want.reach_x, want.reach_y,
                             " got clear=%0b reach=(%0d,%0d)",
                             clear, reach_x, reach_y);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    glpw_in_if  cmd_if ();
    glpw_out_if res_if ();

    grid_line_passability_walk dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if.sink),
        .o_out   (res_if.source)
    );

    walk_scoreboard board = new();

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int n_sent        = 0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watchdog: far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: ready toggles at falling edges, words taken at rising edges
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_result(res_if.clear, res_if.reach_x, res_if.reach_y);
    end

    // Present one word from a falling edge, hold it until taken, return at
    // the next falling edge. Valid stays high between back-to-back words.
    task automatic send_word(t_cmd_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid    = 1'b1;
        cmd_if.cmd      = w.cmd;
        cmd_if.cell_x   = w.cell_x;
        cmd_if.cell_y   = w.cell_y;
        cmd_if.passable = w.passable;
        cmd_if.start_x  = w.start_x;
        cmd_if.start_y  = w.start_y;
        cmd_if.end_x    = w.end_x;
        cmd_if.end_y    = w.end_y;
        do @(posedge i_clk); while (!cmd_if.ready);
        board.note_word(w);
        n_sent++;
        @(negedge i_clk);
    endtask

    // line fields are don't-care on a write, so they carry noise
    task automatic write_cell(int x, int y, bit open);
        t_cmd_word w;
        w.cmd      = CMD_WRITE;
        w.cell_x   = t_field'(x);
        w.cell_y   = t_field'(y);
        w.passable = open;
        w.start_x  = t_field'($urandom_range(FIELD_MAX));
        w.start_y  = t_field'($urandom_range(FIELD_MAX));
        w.end_x    = t_field'($urandom_range(FIELD_MAX));
        w.end_y    = t_field'($urandom_range(FIELD_MAX));
        send_word(w);
    endtask

    // cell fields are don't-care on a check
    task automatic check_line(int x1, int y1, int x2, int y2);
        t_cmd_word w;
        w.cmd      = CMD_CHECK;
        w.cell_x   = t_field'($urandom_range(FIELD_MAX));
        w.cell_y   = t_field'($urandom_range(FIELD_MAX));
        w.passable = 1'($urandom_range(1));
        w.start_x  = t_field'(x1);
        w.start_y  = t_field'(y1);
        w.end_x    = t_field'(x2);
        w.end_y    = t_field'(y2);
        send_word(w);
    endtask

    function automatic int near_coord(int c, int span);
        int d;
        d = int'($urandom_range(2 * span)) - span;
        if (c + d < 0 || c + d > GRID_MASK)
            d = -d;
        return c + d;
    endfunction

    // Open every cell on a random line, sometimes block one of them again,
    // then walk it (and now and then walk it backwards too).
    task automatic run_line(int span);
        int x1;
        int y1;
        int x2;
        int y2;
        int k;
        int px [$];
        int py [$];
        x1 = $urandom_range(GRID_MASK);
        y1 = $urandom_range(GRID_MASK);
        x2 = near_coord(x1, span);
        y2 = near_coord(y1, span);
        case ($urandom_range(7))
            0: begin
                x2 = x1;
            end
            1: begin
                y2 = y1;
            end
            default: ;
        endcase
        board.trace_line(x1, y1, x2, y2);
        px = board.path_x;
        py = board.path_y;
        foreach (px[i]) begin
            if (!board.open_map[board.cell_idx(px[i], py[i])])
                write_cell(px[i], py[i], 1'b1);
        end
        if (px.size() > 0 && $urandom_range(3) == 0) begin
            k = $urandom_range(px.size() - 1);
            write_cell(px[k], py[k], 1'b0);
        end
        check_line(x1, y1, x2, y2);
        if ($urandom_range(9) < 3)
            check_line(x2, y2, x1, y1);
    endtask

    task automatic random_phase(int src_pct, int sink_pct, int n_items);
        int goal;
        int pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        goal          = n_sent + n_items;
        while (n_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 62)
                run_line(($urandom_range(9) == 0) ? 40 : 8);
            else if (pick < 82)
                write_cell($urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                           1'($urandom_range(1)));
            else
                check_line($urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                           $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
        end
    endtask

    initial begin
        cmd_if.valid    = 1'b0;
        cmd_if.cmd      = CMD_WRITE;
        cmd_if.cell_x   = '0;
        cmd_if.cell_y   = '0;
        cmd_if.passable = 1'b0;
        cmd_if.start_x  = '0;
        cmd_if.start_y  = '0;
        cmd_if.end_x    = '0;
        cmd_if.end_y    = '0;
        i_rst_n         = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: map is all blocked right after reset
        check_line(0, 0, 0, 0);               // same cell at the origin corner
        check_line(255, 255, 255, 255);       // same cell at the far corner
        check_line(0, 0, 255, 255);           // blocked at once, reach = start
        write_cell(255, 254, 1'b1);
        write_cell(255, 253, 1'b1);
        check_line(255, 255, 255, 250);       // vertical, downward, blocked at 252, reach 253
        check_line(255, 253, 255, 254);       // vertical, upward, clear
        write_cell(1, 0, 1'b1);
        write_cell(2, 0, 1'b1);
        write_cell(3, 0, 1'b1);
        check_line(0, 0, 3, 0);               // horizontal, start cell untested
        check_line(3, 0, 0, 0);               // reverse: blocked origin at the end
        write_cell(2, 0, 1'b0);               // re-block a cell
        check_line(0, 0, 3, 0);               // now stops at column 1
        write_cell(0, 1, 1'b1);
        write_cell(0, 2, 1'b1);
        check_line(0, 0, 1, 5);               // steep: row run in the first column
        check_line(255, 0, 0, 255);           // falling slope across the grid
        write_cell(255, 255, 1'b1);
        check_line(254, 255, 255, 255);       // single step into the far corner

        // random: receiver idles more, then sender idles more, then no idling
        random_phase(32, 50, 383);
        random_phase(50, 32, 383);
        random_phase(0, 0, 384);

        cmd_if.valid = 1'b0;
        while (board.pending_walks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.pending_walks.size() != 0) begin
            board.mismatches += board.pending_walks.size();
            $display("%0d walk results never arrived", board.pending_walks.size());
        end
        $display("Sent %0d map writes and %0d line checks (%0d clear, %0d blocked)",
                 board.n_writes, board.n_checks, board.n_clear,
                 board.n_checks - board.n_clear);
        $display("Idling swept over sender-heavy, receiver-heavy and none; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
